### hdl/pntp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Prefixed number text parser package
// Shared widths, character codes, parser phases and the hex digit decoder.
// ----------------------------------------------------------------------------
package pntp_pkg;

   // Width of the accumulator; results are sign-extended or cut to OUT_BITS.
   localparam int VALUE_BITS = 32;
   localparam int OUT_BITS   = 32;
   localparam int CHAR_BITS  = 8;
   localparam int BASE_BITS  = 5;

   localparam logic [BASE_BITS-1:0] BASE_RESET = 5'd16;
   localparam logic [BASE_BITS-1:0] BASE_HEX   = 5'd16;
   localparam logic [BASE_BITS-1:0] BASE_DEC   = 5'd10;
   localparam logic [BASE_BITS-1:0] BASE_OCT   = 5'd8;

   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;  // '-'
   localparam logic [CHAR_BITS-1:0] CHAR_TILDE = 8'h7E;  // '~'
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;  // '9'
   localparam logic [CHAR_BITS-1:0] CHAR_LC_A  = 8'h61;  // 'a'
   localparam logic [CHAR_BITS-1:0] CHAR_LC_F  = 8'h66;  // 'f'
   localparam logic [CHAR_BITS-1:0] CHAR_UC_A  = 8'h41;  // 'A'
   localparam logic [CHAR_BITS-1:0] CHAR_UC_F  = 8'h46;  // 'F'
   localparam logic [CHAR_BITS-1:0] CHAR_LC_X  = 8'h78;  // 'x'
   localparam logic [CHAR_BITS-1:0] CHAR_LC_T  = 8'h74;  // 't'

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_SIGN   = 4'b0010,
      PH_ZERO   = 4'b0100,
      PH_DIGITS = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] val;
   } digit_type;

   // Decodes one hex digit in either case.
   function automatic digit_type decode_digit(input logic [CHAR_BITS-1:0] c);
      digit_type d;
      d.valid = 1'b1;
      d.val   = 4'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d.val = 4'(c - CHAR_ZERO);
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
         d.val = 4'(c - CHAR_LC_A + 8'd10);
      end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
         d.val = 4'(c - CHAR_UC_A + 8'd10);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

### hdl/prefixed_number_text_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Prefixed number text parser
// Converts a character stream into signed integers with radix prefixes.
// ----------------------------------------------------------------------------
// Usage: the sender presents one character per request on req_char_code,
// with req_start_req high on the first character of a string. A leading '-'
// negates and a leading '~' inverts the result; then "0x" selects base 16,
// "0t" base 10 and a lone '0' base 8, else the base in csr_write_data
// (written with csr_write_en, reset value 16) applies. The first non-digit
// closes the string and produces one response on rsp_value; later characters
// are dropped until the next start. A start on an open string discards it.
// Path: an accepted request is registered in the input register, and the
// closing character's response is written from there into the response
// register once the response slot is free or being emptied.
// Throughput: one request per cycle while the receiver does not stall; the
// accumulator loop is a single combinational multiply-add by a 5-bit base.
// Reset clears the pipeline, returns the parser to idle and the default
// base to 16. When the receiver stalls, the response register holds; the
// input register takes one more request and then keeps it, with req_ready
// low, until the pending response is taken.
// ----------------------------------------------------------------------------
module prefixed_number_text_parser (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [pntp_pkg::CHAR_BITS-1:0]      req_char_code,
   input  wire                                 req_start_req,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic signed [pntp_pkg::OUT_BITS-1:0] rsp_value,
   input  wire                                 csr_write_en,
   input  wire  [pntp_pkg::BASE_BITS-1:0]      csr_write_data
);
   import pntp_pkg::*;

   // Input register.
   logic                 in_valid_ff;
   logic [CHAR_BITS-1:0] in_char_ff;
   logic                 in_start_ff;

   // Parser state.
   phase_type             phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic                  inv_ff, inv_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [BASE_BITS-1:0]  base_ff, base_in;
   logic [BASE_BITS-1:0]  default_base_ff;

   // Response register.
   logic                        rsp_valid_ff;
   logic signed [OUT_BITS-1:0]  rsp_value_ff, rsp_value_in;

   logic                        fire;
   logic                        emit;
   logic                        take_digit;
   logic [BASE_BITS-1:0]        step_base;
   logic [VALUE_BITS-1:0]       cur_acc;
   logic                        cur_neg;
   logic                        cur_inv;
   logic [VALUE_BITS-1:0]       mac;
   logic signed [VALUE_BITS-1:0] result;
   digit_type                   dig;

   // The registered character is processed when the response slot is free
   // or is being emptied in this cycle.
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   assign dig = decode_digit(in_char_ff);

   // A start clears the flags and accumulator before the character is used.
   assign cur_acc = in_start_ff ? '0 : acc_ff;
   assign cur_neg = in_start_ff ? 1'b0 : neg_ff;
   assign cur_inv = in_start_ff ? 1'b0 : inv_ff;

   assign mac = cur_acc * VALUE_BITS'(step_base) + VALUE_BITS'(dig.val);

   always_comb begin
      priority if (cur_neg) begin
         result = -cur_acc;
      end else if (cur_inv) begin
         result = ~cur_acc;
      end else begin
         result = cur_acc;
      end
   end

   // Sign-extends (or cuts) the accumulator width to the response width.
   assign rsp_value_in = OUT_BITS'(result);

   always_comb begin
      phase_in   = phase_ff;
      neg_in     = neg_ff;
      inv_in     = inv_ff;
      acc_in     = acc_ff;
      base_in    = base_ff;
      step_base  = base_ff;
      take_digit = 1'b0;
      emit       = 1'b0;
      if (fire) begin
         priority if (in_start_ff && in_char_ff == CHAR_MINUS) begin
            neg_in   = 1'b1;
            inv_in   = 1'b0;
            acc_in   = '0;
            phase_in = PH_SIGN;
         end else if (in_start_ff && in_char_ff == CHAR_TILDE) begin
            neg_in   = 1'b0;
            inv_in   = 1'b1;
            acc_in   = '0;
            phase_in = PH_SIGN;
         end else if (in_start_ff || phase_ff == PH_SIGN) begin
            // Prefix position: a '0' may open a radix prefix.
            neg_in = cur_neg;
            inv_in = cur_inv;
            acc_in = cur_acc;
            if (in_char_ff == CHAR_ZERO) begin
               phase_in = PH_ZERO;
            end else begin
               base_in    = default_base_ff;
               step_base  = default_base_ff;
               take_digit = 1'b1;
            end
         end else if (phase_ff == PH_ZERO) begin
            priority if (in_char_ff == CHAR_LC_X) begin
               base_in  = BASE_HEX;
               phase_in = PH_DIGITS;
            end else if (in_char_ff == CHAR_LC_T) begin
               base_in  = BASE_DEC;
               phase_in = PH_DIGITS;
            end else begin
               base_in    = BASE_OCT;
               step_base  = BASE_OCT;
               take_digit = 1'b1;
            end
         end else if (phase_ff == PH_DIGITS) begin
            take_digit = 1'b1;
         end else begin
            // Idle without a start: the character is dropped.
            phase_in = phase_ff;
         end
      end
      if (take_digit) begin
         if (dig.valid) begin
            acc_in   = mac;
            phase_in = PH_DIGITS;
         end else begin
            emit     = 1'b1;
            phase_in = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= PH_IDLE;
         neg_ff          <= 1'b0;
         inv_ff          <= 1'b0;
         acc_ff          <= '0;
         base_ff         <= BASE_RESET;
         default_base_ff <= BASE_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         inv_ff   <= inv_in;
         acc_ff   <= acc_in;
         base_ff  <= base_in;
         if (csr_write_en) begin
            default_base_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff  <= req_char_code;
         in_start_ff <= req_start_req;
      end
      if (emit) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   // A new response appears only when a registered character was processed.
   a_rsp_from_fire: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire))
      else $error("response raised without a processed character");

   // Closing a string always returns the parser to idle.
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      emit |=> phase_ff == PH_IDLE)
      else $error("parser not idle after a response");

   // A pending response is never overwritten while the receiver stalls.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit && rsp_valid_ff |-> rsp_ready)
      else $error("pending response overwritten");

   // An empty input stage always takes a request.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

endmodule
`default_nettype wire
